// ===== hdl/mblos_pkg.sv =====
// Shared widths, command/status types and constant tables for the line-of-sight core.
package mblos_pkg;

    localparam int COORD_W      = 32;             // coordinate width
    localparam int DIFF_W       = COORD_W + 1;    // point minus centre
    localparam int RAD_W        = 31;             // radius width
    localparam int FRAC         = 29;             // Q1.29 / Q3.29 fraction bits
    localparam int MAG_W        = FRAC + 1;       // scaled magnitude, below 2^30
    localparam int ROOT_W       = 31;             // integer square root width
    localparam int SQ_W         = 2 * ROOT_W;     // radicand width
    localparam int Q_W          = FRAC + 1;       // quotient width, at most 2^29
    localparam int U_W          = FRAC + 2;       // signed Q1.29 value
    localparam int PROD_W       = 2 * U_W;        // product width
    localparam int ACC_W        = 64;             // accumulator width
    localparam int CORD_W       = 34;             // CORDIC x / y width
    localparam int ANG_W        = 34;             // angle width, Q3.29 plus headroom
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;

    localparam logic [SQ_W-1:0]         ONE_SQ  = SQ_W'(1) << (2 * FRAC);
    localparam logic signed [U_W-1:0]   ONE_Q   = U_W'(1) << FRAC;
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) << FRAC;
    localparam logic signed [ANG_W-1:0] HALF_PI = 34'sd843314857;

    // multiplier operand select
    localparam logic [1:0] MUL_SQ   = 2'd0;
    localparam logic [1:0] MUL_DOT  = 2'd1;
    localparam logic [1:0] MUL_ACOS = 2'd2;

    typedef struct packed {
        logic              cap;
        logic              load_vec;
        logic              sel_t;
        logic              mul_en;
        logic [1:0]        mul_op;
        logic [1:0]        idx;
        logic              acc_clr;
        logic              acc_add;
        logic              sq_start;
        logic              sq_acos;
        logic              n_latch;
        logic              div_start;
        logic              div_store;
        logic              clamp;
        logic              cor_init;
        logic              cor_step;
        logic [STEP_W-1:0] step;
        logic              zacc;
        logic              cmp;
        logic              blk;
        logic              commit;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic blk;
        logic sq_done;
        logic div_done;
        logic last;
        logic oval;
    } t_stat;

    // atan(2^-i) in Q3.29, rounded
    function automatic logic signed [ANG_W-1:0] atan_q(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 34'sd421657428;
            5'd1:    v = 34'sd248918915;
            5'd2:    v = 34'sd131521918;
            5'd3:    v = 34'sd66762579;
            5'd4:    v = 34'sd33510843;
            5'd5:    v = 34'sd16771758;
            5'd6:    v = 34'sd8387925;
            5'd7:    v = 34'sd4194219;
            5'd8:    v = 34'sd2097141;
            5'd9:    v = 34'sd1048575;
            default: v = $signed({{(ANG_W-1){1'b0}}, 1'b1} << (5'(FRAC) - i));
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/mblos_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module mblos_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mblos_pkg::SQ_W-1:0]      i_val,
    output logic [mblos_pkg::ROOT_W-1:0]    o_root,
    output logic                            o_done
);
    logic [mblos_pkg::SQ_W-1:0]     r_val;
    logic [mblos_pkg::ROOT_W+1:0]   r_rem;
    logic [mblos_pkg::ROOT_W-1:0]   r_res;
    logic [mblos_pkg::STEP_W-1:0]   r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [mblos_pkg::ROOT_W+3:0]   rem2;
    logic [mblos_pkg::ROOT_W+3:0]   trial;
    logic [mblos_pkg::ROOT_W+3:0]   diff;
    logic                           ge;

    always_comb begin
        rem2  = {r_rem, r_val[mblos_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, r_res, 2'b01};
        ge    = rem2 >= trial;
        diff  = rem2 - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mblos_pkg::STEP_W'(mblos_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_val;
            r_rem <= '0;
            r_res <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 2;
            r_rem <= ge ? diff[mblos_pkg::ROOT_W+1:0] : rem2[mblos_pkg::ROOT_W+1:0];
            r_res <= {r_res[mblos_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_root = r_res;
    assign o_done = r_done;
endmodule

// ===== hdl/mblos_div.sv =====
// Restoring divider: floor(num * 2^29 / den), one quotient bit per cycle.
module mblos_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mblos_pkg::ROOT_W-1:0]    i_num,
    input  logic [mblos_pkg::ROOT_W-1:0]    i_den,
    output logic [mblos_pkg::Q_W-1:0]       o_quo,
    output logic                            o_done
);
    logic [mblos_pkg::ROOT_W:0]     r_rem;
    logic [mblos_pkg::ROOT_W-1:0]   r_den;
    logic [mblos_pkg::Q_W-1:0]      r_quo;
    logic [mblos_pkg::STEP_W-1:0]   r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic                           ge;
    logic [mblos_pkg::ROOT_W:0]     sub;

    always_comb begin
        ge  = r_rem >= {1'b0, r_den};
        sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mblos_pkg::STEP_W'(mblos_pkg::Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {sub[mblos_pkg::ROOT_W-1:0], 1'b0};
            r_quo <= {r_quo[mblos_pkg::Q_W-2:0], ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

// ===== hdl/mblos_dp.sv =====
// Datapath: difference vectors, scaling, shared multiplier, root, divider and CORDIC.
module mblos_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_z,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_z,
    input  logic [mblos_pkg::RAD_W-1:0]         i_body_radius,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_z,
    input  logic                                i_last_body,
    input  logic                                i_ready,
    input  mblos_pkg::t_cmd                     i_cmd,
    output mblos_pkg::t_stat                    o_stat,
    output logic                                o_valid,
    output logic                                o_visible
);
    localparam int DW = mblos_pkg::DIFF_W;

    logic signed [DW-1:0]                       r_vs [3];
    logic signed [DW-1:0]                       r_vt [3];
    logic [mblos_pkg::RAD_W-1:0]                r_rad;
    logic                                       r_last;
    logic [mblos_pkg::MAG_W-1:0]                r_a [3];
    logic [mblos_pkg::MAG_W-1:0]                r_rs;
    logic signed [mblos_pkg::PROD_W-1:0]        r_prod;
    logic signed [mblos_pkg::ACC_W-1:0]         r_acc;
    logic [mblos_pkg::ROOT_W-1:0]               r_n;
    logic signed [mblos_pkg::U_W-1:0]           r_us [3];
    logic signed [mblos_pkg::U_W-1:0]           r_ut [3];
    logic signed [mblos_pkg::U_W-1:0]           r_cos [3];
    logic signed [mblos_pkg::CORD_W-1:0]        r_x;
    logic signed [mblos_pkg::CORD_W-1:0]        r_y;
    logic signed [mblos_pkg::ANG_W-1:0]         r_z;
    logic signed [mblos_pkg::ANG_W-1:0]         r_zsum;
    logic                                       r_clr;
    logic                                       r_run;
    logic                                       r_oval;
    logic                                       r_ovis;

    logic signed [DW-1:0]                       v [3];
    logic [DW-1:0]                              m [3];
    logic [DW-1:0]                              mx;
    logic [1:0]                                 sh;
    logic signed [mblos_pkg::U_W-1:0]           opa;
    logic signed [mblos_pkg::U_W-1:0]           opb;
    logic signed [mblos_pkg::PROD_W-1:0]        mul_p;
    logic [mblos_pkg::SQ_W-1:0]                 sq_in;
    logic [mblos_pkg::ROOT_W-1:0]               root;
    logic                                       sq_done;
    logic [mblos_pkg::ROOT_W-1:0]               div_num;
    logic [mblos_pkg::Q_W-1:0]                  div_q;
    logic                                       div_done;
    logic [1:0]                                 vidx;
    logic signed [mblos_pkg::U_W-1:0]           qs;
    logic signed [mblos_pkg::ACC_W-1:0]         c64;
    logic signed [mblos_pkg::CORD_W-1:0]        cs;
    logic signed [mblos_pkg::CORD_W-1:0]        ss;
    logic signed [mblos_pkg::CORD_W-1:0]        xs;
    logic signed [mblos_pkg::CORD_W-1:0]        ys;

    // magnitudes and common scale of the selected vector with the radius
    always_comb begin
        mx = {{(DW-mblos_pkg::RAD_W){1'b0}}, r_rad};
        for (int i = 0; i < 3; i++) begin
            v[i] = i_cmd.sel_t ? r_vt[i] : r_vs[i];
            m[i] = v[i][DW-1] ? $unsigned(-v[i]) : $unsigned(v[i]);
        end
        for (int i = 0; i < 3; i++) begin
            if (m[i] > mx) mx = m[i];
        end
        if (mx[DW-1])                   sh = 2'd3;
        else if (mx[DW-2])              sh = 2'd2;
        else if (mx[mblos_pkg::MAG_W])  sh = 2'd1;
        else                            sh = 2'd0;
    end

    always_comb begin
        case (i_cmd.mul_op)
            mblos_pkg::MUL_SQ: begin
                opa = $signed({1'b0, r_a[i_cmd.idx]});
                opb = $signed({1'b0, r_a[i_cmd.idx]});
            end
            mblos_pkg::MUL_DOT: begin
                opa = r_us[i_cmd.idx];
                opb = r_ut[i_cmd.idx];
            end
            mblos_pkg::MUL_ACOS: begin
                opa = r_cos[i_cmd.idx];
                opb = r_cos[i_cmd.idx];
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        mul_p = opa * opb;
    end

    assign sq_in = i_cmd.sq_acos ? (mblos_pkg::ONE_SQ - r_prod[mblos_pkg::SQ_W-1:0])
                                 : r_acc[mblos_pkg::SQ_W-1:0];
    assign vidx    = 2'(i_cmd.idx - 2'd1);
    assign div_num = (i_cmd.idx == 2'd0) ? {1'b0, r_rs} : {1'b0, r_a[vidx]};
    assign qs      = $signed({1'b0, div_q});
    assign c64     = r_acc >>> mblos_pkg::FRAC;
    assign cs      = mblos_pkg::CORD_W'(r_cos[i_cmd.idx]);
    assign ss      = $signed({{(mblos_pkg::CORD_W-mblos_pkg::ROOT_W){1'b0}}, root});
    assign xs      = r_x >>> i_cmd.step;
    assign ys      = r_y >>> i_cmd.step;

    mblos_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_val   (sq_in),
        .o_root  (root),
        .o_done  (sq_done)
    );

    mblos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_n),
        .o_quo   (div_q),
        .o_done  (div_done)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_vs[0] <= {i_src_x[mblos_pkg::COORD_W-1], i_src_x} -
                       {i_body_x[mblos_pkg::COORD_W-1], i_body_x};
            r_vs[1] <= {i_src_y[mblos_pkg::COORD_W-1], i_src_y} -
                       {i_body_y[mblos_pkg::COORD_W-1], i_body_y};
            r_vs[2] <= {i_src_z[mblos_pkg::COORD_W-1], i_src_z} -
                       {i_body_z[mblos_pkg::COORD_W-1], i_body_z};
            r_vt[0] <= {i_tgt_x[mblos_pkg::COORD_W-1], i_tgt_x} -
                       {i_body_x[mblos_pkg::COORD_W-1], i_body_x};
            r_vt[1] <= {i_tgt_y[mblos_pkg::COORD_W-1], i_tgt_y} -
                       {i_body_y[mblos_pkg::COORD_W-1], i_body_y};
            r_vt[2] <= {i_tgt_z[mblos_pkg::COORD_W-1], i_tgt_z} -
                       {i_body_z[mblos_pkg::COORD_W-1], i_body_z};
            r_rad   <= i_body_radius;
            r_last  <= i_last_body;
        end
        if (i_cmd.load_vec) begin
            for (int i = 0; i < 3; i++) r_a[i] <= mblos_pkg::MAG_W'(m[i] >> sh);
            r_rs <= mblos_pkg::MAG_W'(r_rad >> sh);
        end
        if (i_cmd.mul_en) r_prod <= mul_p;
        if (i_cmd.acc_clr)
            r_acc <= '0;
        else if (i_cmd.acc_add)
            r_acc <= r_acc + mblos_pkg::ACC_W'(r_prod);
        if (i_cmd.n_latch) r_n <= root;
        if (i_cmd.div_store) begin
            if (i_cmd.idx == 2'd0)
                r_cos[{1'b0, i_cmd.sel_t}] <= qs;
            else if (i_cmd.sel_t)
                r_ut[vidx] <= v[vidx][DW-1] ? -qs : qs;
            else
                r_us[vidx] <= v[vidx][DW-1] ? -qs : qs;
        end
        if (i_cmd.clamp) begin
            if (c64 > mblos_pkg::ACC_ONE)       r_cos[2] <= mblos_pkg::ONE_Q;
            else if (c64 < -mblos_pkg::ACC_ONE) r_cos[2] <= -mblos_pkg::ONE_Q;
            else                                r_cos[2] <= mblos_pkg::U_W'(c64);
            r_zsum <= '0;
        end else if (i_cmd.zacc) begin
            r_zsum <= r_zsum + r_z;
        end
        if (i_cmd.cor_init) begin
            // negative cosine: pre-rotate by -90 degrees, start at pi/2
            if (cs < 0) begin
                r_x <= ss;
                r_y <= -cs;
                r_z <= mblos_pkg::HALF_PI;
            end else begin
                r_x <= cs;
                r_y <= ss;
                r_z <= '0;
            end
        end else if (i_cmd.cor_step) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + mblos_pkg::atan_q(i_cmd.step);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - mblos_pkg::atan_q(i_cmd.step);
            end
        end
        if (i_cmd.blk)
            r_clr <= 1'b0;
        else if (i_cmd.cmp)
            r_clr <= r_zsum > r_z;
        if (i_cmd.emit) r_ovis <= r_run & r_clr;
    end

    // control state: running verdict and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b1;
            r_oval <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_run  <= 1'b1;
                r_oval <= 1'b1;
            end else begin
                if (i_cmd.commit) r_run <= r_run & r_clr;
                if (i_ready)      r_oval <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.blk      = ({1'b0, r_rs} > r_n) || (r_n == '0);
        o_stat.sq_done  = sq_done;
        o_stat.div_done = div_done;
        o_stat.last     = r_last;
        o_stat.oval     = r_oval;
    end

    assign o_valid   = r_oval;
    assign o_visible = r_ovis;
endmodule

// ===== hdl/mblos_ctrl.sv =====
// Sequencer that steps the datapath through one body test per item.
module mblos_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ready,
    input  mblos_pkg::t_stat    i_stat,
    output logic                o_ready,
    output mblos_pkg::t_cmd     o_cmd
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_VEC  = 5'd1;
    localparam logic [4:0] S_SQ   = 5'd2;
    localparam logic [4:0] S_SQS  = 5'd3;
    localparam logic [4:0] S_SQW  = 5'd4;
    localparam logic [4:0] S_CHK  = 5'd5;
    localparam logic [4:0] S_DVS  = 5'd6;
    localparam logic [4:0] S_DVW  = 5'd7;
    localparam logic [4:0] S_DOT  = 5'd8;
    localparam logic [4:0] S_CLP  = 5'd9;
    localparam logic [4:0] S_AMUL = 5'd10;
    localparam logic [4:0] S_ASQS = 5'd11;
    localparam logic [4:0] S_ASQW = 5'd12;
    localparam logic [4:0] S_COR  = 5'd13;
    localparam logic [4:0] S_AEND = 5'd14;
    localparam logic [4:0] S_DONE = 5'd15;

    logic [4:0]                     r_state, n_state;
    logic [mblos_pkg::STEP_W-1:0]   r_cnt, n_cnt;
    logic [1:0]                     r_k, n_k;
    logic                           r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel_t = r_sel;
        o_cmd.idx   = r_cnt[1:0];
        o_cmd.step  = r_cnt;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_sel     = 1'b0;
                    n_state   = S_VEC;
                end
            end
            S_VEC: begin
                o_cmd.load_vec = 1'b1;
                o_cmd.acc_clr  = 1'b1;
                n_cnt          = '0;
                n_state        = S_SQ;
            end
            S_SQ, S_DOT: begin
                o_cmd.mul_op  = (r_state == S_SQ) ? mblos_pkg::MUL_SQ : mblos_pkg::MUL_DOT;
                o_cmd.mul_en  = (r_cnt != 5'd3);
                o_cmd.acc_add = (r_cnt != 5'd0);
                if (r_cnt == 5'd3) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_SQ) ? S_SQS : S_CLP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQS: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_SQW;
            end
            S_SQW: begin
                if (i_stat.sq_done) begin
                    o_cmd.n_latch = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                n_cnt = '0;
                if (i_stat.blk) begin
                    o_cmd.blk = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_DVS;
                end
            end
            S_DVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DVW;
            end
            S_DVW: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_cnt == 5'd3) begin
                        n_cnt = '0;
                        if (!r_sel) begin
                            n_sel   = 1'b1;
                            n_state = S_VEC;
                        end else begin
                            o_cmd.acc_clr = 1'b1;
                            n_state       = S_DOT;
                        end
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_DVS;
                    end
                end
            end
            S_CLP: begin
                o_cmd.clamp = 1'b1;
                n_k         = '0;
                n_state     = S_AMUL;
            end
            S_AMUL: begin
                o_cmd.idx    = r_k;
                o_cmd.mul_op = mblos_pkg::MUL_ACOS;
                o_cmd.mul_en = 1'b1;
                n_state      = S_ASQS;
            end
            S_ASQS: begin
                o_cmd.sq_start = 1'b1;
                o_cmd.sq_acos  = 1'b1;
                n_state        = S_ASQW;
            end
            S_ASQW: begin
                if (i_stat.sq_done) begin
                    o_cmd.idx      = r_k;
                    o_cmd.cor_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_COR;
                end
            end
            S_COR: begin
                o_cmd.cor_step = 1'b1;
                if (r_cnt == mblos_pkg::STEP_W'(mblos_pkg::CORDIC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_AEND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_AEND: begin
                if (r_k != 2'd2) begin
                    o_cmd.zacc = 1'b1;
                    n_k        = r_k + 1'b1;
                    n_state    = S_AMUL;
                end else begin
                    o_cmd.cmp = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.last) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (!i_stat.oval || i_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

// ===== hdl/multi_body_line_of_sight_test_core.sv =====
// Line-of-sight test of a source-target pair against spherical bodies, one body per item.
// A last-body item gives a valid result once its final body test ends (sooner when a
// radius exceeds a distance); a previous result that waits for ready holds it back.
// Items do not overlap; the shared 31-step root and 30-step divider units (four divisions
// per vector) and three 30-step CORDIC passes run in turn for each item.
// Reset: synchronous active-low; clears the sequencer, empties the result register and
// sets the running verdict to visible.
module multi_body_line_of_sight_test_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_src_z,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_body_z,
    input  logic [mblos_pkg::RAD_W-1:0]         i_body_radius,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_x,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_y,
    input  logic signed [mblos_pkg::COORD_W-1:0] i_tgt_z,
    input  logic                                i_last_body,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_visible
);
    mblos_pkg::t_cmd  cmd;
    mblos_pkg::t_stat stat;

    mblos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    mblos_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_src_z       (i_src_z),
        .i_body_x      (i_body_x),
        .i_body_y      (i_body_y),
        .i_body_z      (i_body_z),
        .i_body_radius (i_body_radius),
        .i_tgt_x       (i_tgt_x),
        .i_tgt_y       (i_tgt_y),
        .i_tgt_z       (i_tgt_z),
        .i_last_body   (i_last_body),
        .i_ready       (i_ready),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_visible     (o_visible)
    );
endmodule

// ===== hdl/mblos_chk.sv =====
// Port-level checker for the line-of-sight core, bound to the top level.
module mblos_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic i_last_body,
    input logic o_valid,
    input logic i_ready,
    input logic o_visible
);
    // a waiting result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_visible))
        else $error("result item changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result register not empty after reset");

    // one item in flight: ready drops right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while busy");

    a_no_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_body |=> !$rose(o_valid))
        else $error("result appeared too early");
endmodule

bind multi_body_line_of_sight_test_core mblos_chk u_chk (.*);
